@@ hw/rtl/alu8f_pkg.sv @@
package alu8f_pkg;

    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_ADC  = 5'd1;
    localparam logic [4:0] OP_SUB  = 5'd2;
    localparam logic [4:0] OP_SBC  = 5'd3;
    localparam logic [4:0] OP_AND  = 5'd4;
    localparam logic [4:0] OP_XOR  = 5'd5;
    localparam logic [4:0] OP_OR   = 5'd6;
    localparam logic [4:0] OP_CP   = 5'd7;
    localparam logic [4:0] OP_INC  = 5'd8;
    localparam logic [4:0] OP_DEC  = 5'd9;
    localparam logic [4:0] OP_RLC  = 5'd10;
    localparam logic [4:0] OP_RRC  = 5'd11;
    localparam logic [4:0] OP_RL   = 5'd12;
    localparam logic [4:0] OP_RR   = 5'd13;
    localparam logic [4:0] OP_SLA  = 5'd14;
    localparam logic [4:0] OP_SRA  = 5'd15;
    localparam logic [4:0] OP_SRL  = 5'd16;
    localparam logic [4:0] OP_SWAP = 5'd17;
    localparam logic [4:0] OP_RLCA = 5'd18;
    localparam logic [4:0] OP_RRCA = 5'd19;
    localparam logic [4:0] OP_RLA  = 5'd20;
    localparam logic [4:0] OP_RRA  = 5'd21;
    localparam logic [4:0] OP_BIT  = 5'd22;
    localparam logic [4:0] OP_RES  = 5'd23;
    localparam logic [4:0] OP_SET  = 5'd24;
    localparam logic [4:0] OP_CPL  = 5'd25;
    localparam logic [4:0] OP_CCF  = 5'd26;
    localparam logic [4:0] OP_SCF  = 5'd27;

    localparam logic [2:0] SH_RLC  = 3'd0;
    localparam logic [2:0] SH_RRC  = 3'd1;
    localparam logic [2:0] SH_RL   = 3'd2;
    localparam logic [2:0] SH_RR   = 3'd3;
    localparam logic [2:0] SH_SLA  = 3'd4;
    localparam logic [2:0] SH_SRA  = 3'd5;
    localparam logic [2:0] SH_SRL  = 3'd6;
    localparam logic [2:0] SH_SWAP = 3'd7;

    typedef struct packed {
        logic [4:0] operation;
        logic [7:0] accumulator;
        logic [7:0] operand;
        logic [2:0] bit_index;
        logic       zero_in;
        logic       subtract_in;
        logic       half_carry_in;
        logic       carry_in;
    } t_alu_in;

    typedef struct packed {
        logic [7:0] result;
        logic       write_result;
        logic       zero_out;
        logic       subtract_out;
        logic       half_carry_out;
        logic       carry_out;
    } t_alu_out;

endpackage

@@ hw/rtl/cpu_8bit_alu_with_flags.sv @@
// Channel   Ports                    Transfer
// --------  -----------------------  -----------------------------------
// input     start, busy, i_item      edge with start high and busy low
// result    o_valid, o_result        edge ending the cycle o_valid is high
//
// One item per cycle; busy is always low. The input register and the result
// register are the only stages, and a result passes through both in that order.
// Synchronous active-low reset clears both valid flags; payload is not reset.
// The receiver cannot stall, so each result is held for exactly one cycle.
module cpu_8bit_alu_with_flags
    import alu8f_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_alu_in  i_item,
    output logic     o_valid,
    output t_alu_out o_result
);

    t_alu_in  r_in;
    logic     r_in_vld;
    t_alu_out r_out;
    logic     r_out_vld;
    t_alu_out n_out;

    logic [8:0] sum9;
    logic [4:0] sum5;
    logic [8:0] dif9;
    logic [4:0] dif5;
    logic       cin;
    logic [8:0] sh;
    logic [2:0] sh_kind;
    logic [7:0] bit_mask;

    function automatic logic [8:0] shift_byte(
        input logic [2:0] kind,
        input logic [7:0] v,
        input logic       ci
    );
        logic [8:0] res;
        begin
            case (kind)
                SH_RLC:  res = {v[7], v[6:0], v[7]};
                SH_RRC:  res = {v[0], v[0], v[7:1]};
                SH_RL:   res = {v[7], v[6:0], ci};
                SH_RR:   res = {v[0], ci, v[7:1]};
                SH_SLA:  res = {v[7], v[6:0], 1'b0};
                SH_SRA:  res = {v[0], v[7], v[7:1]};
                SH_SRL:  res = {v[0], 1'b0, v[7:1]};
                default: res = {1'b0, v[3:0], v[7:4]};
            endcase
            return res;
        end
    endfunction

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start && !busy;
            r_out_vld <= r_in_vld;
        end
        if (start && !busy) begin
            r_in <= i_item;
        end
        r_out <= n_out;
    end

    always_comb begin
        cin = ((r_in.operation == OP_ADC) || (r_in.operation == OP_SBC)) ? r_in.carry_in : 1'b0;
        sum9 = {1'b0, r_in.accumulator} + {1'b0, r_in.operand} + {8'd0, cin};
        sum5 = {1'b0, r_in.accumulator[3:0]} + {1'b0, r_in.operand[3:0]} + {4'd0, cin};
        dif9 = {1'b0, r_in.accumulator} - {1'b0, r_in.operand} - {8'd0, cin};
        dif5 = {1'b0, r_in.accumulator[3:0]} - {1'b0, r_in.operand[3:0]} - {4'd0, cin};
        sh_kind = (r_in.operation >= OP_RLCA) ? 3'(r_in.operation - OP_RLCA)
                                               : 3'(r_in.operation - OP_RLC);
        sh = shift_byte(sh_kind,
                        (r_in.operation >= OP_RLCA) ? r_in.accumulator : r_in.operand,
                        r_in.carry_in);
        bit_mask = 8'd1 << r_in.bit_index;

        n_out.result         = r_in.accumulator;
        n_out.write_result   = 1'b1;
        n_out.zero_out       = r_in.zero_in;
        n_out.subtract_out   = r_in.subtract_in;
        n_out.half_carry_out = r_in.half_carry_in;
        n_out.carry_out      = r_in.carry_in;

        case (r_in.operation) inside
            OP_ADD, OP_ADC: begin
                n_out.result         = sum9[7:0];
                n_out.zero_out       = (sum9[7:0] == 8'd0);
                n_out.subtract_out   = 1'b0;
                n_out.half_carry_out = sum5[4];
                n_out.carry_out      = sum9[8];
            end
            OP_SUB, OP_SBC, OP_CP: begin
                n_out.result         = (r_in.operation == OP_CP) ? r_in.accumulator : dif9[7:0];
                n_out.write_result   = (r_in.operation != OP_CP);
                n_out.zero_out       = (dif9[7:0] == 8'd0);
                n_out.subtract_out   = 1'b1;
                n_out.half_carry_out = dif5[4];
                n_out.carry_out      = dif9[8];
            end
            OP_AND, OP_XOR, OP_OR: begin
                if (r_in.operation == OP_AND) begin
                    n_out.result = r_in.accumulator & r_in.operand;
                end else if (r_in.operation == OP_XOR) begin
                    n_out.result = r_in.accumulator ^ r_in.operand;
                end else begin
                    n_out.result = r_in.accumulator | r_in.operand;
                end
                n_out.zero_out       = (n_out.result == 8'd0);
                n_out.subtract_out   = 1'b0;
                n_out.half_carry_out = (r_in.operation == OP_AND);
                n_out.carry_out      = 1'b0;
            end
            OP_INC: begin
                n_out.result         = r_in.operand + 8'd1;
                n_out.zero_out       = (r_in.operand == 8'hFF);
                n_out.subtract_out   = 1'b0;
                n_out.half_carry_out = (r_in.operand[3:0] == 4'hF);
            end
            OP_DEC: begin
                n_out.result         = r_in.operand - 8'd1;
                n_out.zero_out       = (r_in.operand == 8'h01);
                n_out.subtract_out   = 1'b1;
                n_out.half_carry_out = (r_in.operand[3:0] == 4'h0);
            end
            [OP_RLC:OP_SWAP], [OP_RLCA:OP_RRA]: begin
                n_out.result         = sh[7:0];
                n_out.zero_out       = (r_in.operation < OP_RLCA) && (sh[7:0] == 8'd0);
                n_out.subtract_out   = 1'b0;
                n_out.half_carry_out = 1'b0;
                n_out.carry_out      = sh[8];
            end
            OP_BIT: begin
                n_out.result         = r_in.operand;
                n_out.write_result   = 1'b0;
                n_out.zero_out       = ~r_in.operand[r_in.bit_index];
                n_out.subtract_out   = 1'b0;
                n_out.half_carry_out = 1'b1;
            end
            OP_RES: begin
                n_out.result = r_in.operand & ~bit_mask;
            end
            OP_SET: begin
                n_out.result = r_in.operand | bit_mask;
            end
            OP_CPL: begin
                n_out.result         = ~r_in.accumulator;
                n_out.subtract_out   = 1'b1;
                n_out.half_carry_out = 1'b1;
            end
            OP_CCF, OP_SCF: begin
                n_out.write_result   = 1'b0;
                n_out.subtract_out   = 1'b0;
                n_out.half_carry_out = 1'b0;
                n_out.carry_out      = (r_in.operation == OP_SCF) | ~r_in.carry_in;
            end
            default: begin
                n_out.write_result = 1'b0;
            end
        endcase
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_start_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("accepted transfer produced no result");

    a_result_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 2))
        else $error("result without accepted transfer");

    a_acc_rotate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && ((r_in.operation == OP_RLCA) || (r_in.operation == OP_RRCA) ||
                      (r_in.operation == OP_RLA) || (r_in.operation == OP_RRA)))
        |=> !o_result.zero_out)
        else $error("accumulator rotate left zero flag set");

    a_cp_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && ((r_in.operation == OP_CP) || (r_in.operation == OP_BIT)))
        |=> (o_valid && !o_result.write_result))
        else $error("compare or bit test requested write back");
`endif

endmodule
